// File: rtl/fingerprint_module_command_sequencer_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the fingerprint module command sequencer
// Concurrent checks clocked on clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef FINGERPRINT_MODULE_COMMAND_SEQUENCER_MACROS_SVH
`define FINGERPRINT_MODULE_COMMAND_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define FPSEQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define FPSEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FPSEQ_ASSERT_NOW(lbl, ante, cons, msg)
`define FPSEQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/fpseq_pkg.sv
// ---------------------------------------------------------------------------
// fpseq_pkg
// Types, codes and helpers shared by the command sequencer modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpseq_pkg;

    // Input action codes
    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_REPLY  = 3'd1;
    localparam logic [2:0] ACT_ENROLL = 3'd2;
    localparam logic [2:0] ACT_VERIFY = 3'd3;
    localparam logic [2:0] ACT_DELETE = 3'd4;
    localparam logic [2:0] ACT_CLEAR  = 3'd5;
    localparam logic [2:0] ACT_CANCEL = 3'd6;
    localparam logic [2:0] ACT_LED    = 3'd7;

    // Module instruction codes
    localparam logic [7:0] OPC_GET_IMAGE = 8'h01;
    localparam logic [7:0] OPC_DELETE    = 8'h0C;
    localparam logic [7:0] OPC_EMPTY     = 8'h0D;
    localparam logic [7:0] OPC_CANCEL    = 8'h30;
    localparam logic [7:0] OPC_ENROLL    = 8'h31;
    localparam logic [7:0] OPC_IDENTIFY  = 8'h32;
    localparam logic [7:0] OPC_LED_CTRL  = 8'h3C;
    localparam logic [7:0] OPC_LED_MODE  = 8'h60;

    // Reply bytes of interest
    localparam logic [7:0]  CONF_OK        = 8'h00;
    localparam logic [7:0]  CONF_SILENT    = 8'h26;
    localparam logic [7:0]  STEP_ENROLL_MAX = 8'd5;
    localparam logic [7:0]  STEP_STORED    = 8'd6;
    localparam logic [7:0]  STEP_IDENT     = 8'd5;
    localparam logic [15:0] CODE_NO_MATCH  = 16'h0009;
    localparam logic [7:0]  LED_AUTO_BYTE  = 8'hFF;

    // Flash colours
    localparam logic [2:0] LED_OFF   = 3'd0;
    localparam logic [2:0] LED_GREEN = 3'd2;
    localparam logic [2:0] LED_RED   = 3'd4;

    // Result kinds
    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_NOTE = 1'b1;

    // Notification codes
    localparam logic [3:0] NOTE_BUSY        = 4'd0;
    localparam logic [3:0] NOTE_TIMEOUT     = 4'd1;
    localparam logic [3:0] NOTE_ENROLL_STEP = 4'd2;
    localparam logic [3:0] NOTE_ENROLL_OK   = 4'd3;
    localparam logic [3:0] NOTE_ENROLL_FAIL = 4'd4;
    localparam logic [3:0] NOTE_VERIFY_OK   = 4'd5;
    localparam logic [3:0] NOTE_VERIFY_FAIL = 4'd6;
    localparam logic [3:0] NOTE_DELETE_OK   = 4'd7;
    localparam logic [3:0] NOTE_DELETE_FAIL = 4'd8;
    localparam logic [3:0] NOTE_CLEAR_OK    = 4'd9;
    localparam logic [3:0] NOTE_CLEAR_FAIL  = 4'd10;
    localparam logic [3:0] NOTE_CANCELLED   = 4'd11;
    localparam logic [3:0] NOTE_LED_OK      = 4'd12;
    localparam logic [3:0] NOTE_LED_FAIL    = 4'd13;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPTION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE  = 2'd3;

    // Configuration reset values
    localparam logic [7:0]  CFG_REPEAT_RST = 8'd4;
    localparam logic [15:0] CFG_OPTION_RST = 16'd0;
    localparam logic [7:0]  CFG_LEVEL_RST  = 8'd2;
    localparam logic [15:0] CFG_RANGE_RST  = 16'hFFFF;

    // Default timeouts in ticks
    localparam logic [15:0] ENROLL_TIMEOUT_DEF = 16'd2000;
    localparam logic [15:0] VERIFY_TIMEOUT_DEF = 16'd2000;
    localparam logic [15:0] REPLY_TIMEOUT_DEF  = 16'd200;

    // Queue depth between front and back
    localparam int Q_DEPTH = 2;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_ENROLL = 3'd1,
        MODE_VERIFY = 3'd2,
        MODE_DELETE = 3'd3,
        MODE_CLEAR  = 3'd4,
        MODE_CANCEL = 3'd5,
        MODE_LED    = 3'd6
    } op_mode_t;

    typedef enum logic [1:0] {
        PH_IDENTIFY = 2'd0,
        PH_FLASH    = 2'd1,
        PH_POLL     = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        EV_TICK,
        EV_REPLY,
        EV_START,
        EV_CANCEL
    } ev_kind_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] request_id;
        logic        request_auto;
        logic [7:0]  reply_confirm;
        logic [7:0]  reply_step;
        logic [7:0]  reply_seq;
        logic [15:0] reply_page;
        logic [15:0] reply_score;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  cmd_opcode;
        logic [39:0] cmd_bytes;
        logic [2:0]  cmd_byte_count;
        logic [3:0]  note_code;
        logic [15:0] note_arg_a;
        logic [15:0] note_arg_b;
        logic        is_last;
    } out_item_t;

    // Classified transaction held in the queue
    typedef struct packed {
        ev_kind_t    kind;
        op_mode_t    start_mode;
        logic [15:0] request_id;
        logic        request_auto;
        logic [7:0]  confirm;
        logic [7:0]  step;
        logic [7:0]  seq;
        logic [15:0] page;
        logic [15:0] score;
        logic        conf_ok;
        logic        conf_silent;
        logic        ident_hit;
    } item_t;

    typedef struct packed {
        logic [7:0]  repeat_count;
        logic [15:0] option_word;
        logic [7:0]  score_level;
        logic [15:0] range_id;
    } cfg_t;

    // Back end status seen by the queue and the top level
    typedef struct packed {
        logic pop;
        logic pend_valid;
        logic out_valid;
    } back_status_t;

    function automatic out_item_t mk_cmd(input logic [7:0] opc, input logic [39:0] bytes,
                                         input logic [2:0] cnt);
        out_item_t r;
        r                = '0;
        r.result_kind    = KIND_CMD;
        r.cmd_opcode     = opc;
        r.cmd_bytes      = bytes;
        r.cmd_byte_count = cnt;
        return r;
    endfunction

    function automatic out_item_t mk_note(input logic [3:0] code, input logic [15:0] a,
                                          input logic [15:0] b);
        out_item_t r;
        r             = '0;
        r.result_kind = KIND_NOTE;
        r.note_code   = code;
        r.note_arg_a  = a;
        r.note_arg_b  = b;
        return r;
    endfunction

endpackage

// File: rtl/fingerprint_module_command_sequencer.sv
// ---------------------------------------------------------------------------
// fingerprint_module_command_sequencer
// Host-side command sequencer for a fingerprint module: front classifier,
// transaction queue and back-end operation sequencer.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------
//   in      | input     | in_valid / in_stall | in_data   (in_item_t)
//   out     | output    | out_valid/out_stall | out_data  (out_item_t)
//   cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// One transaction is accepted per cycle while the two-entry queue has room.
// The back end retires one transaction per cycle while the result register is free
// and no second result waits; an identify outcome with its LED flash command also
// fills the holding stage. A result passes a queue slot, then the result register.
// Reset is asynchronous; no clearing pass, the block is ready at once.
// out_stall holds the result register; the queue then fills and stalls in.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "fingerprint_module_command_sequencer_macros.svh"

module fingerprint_module_command_sequencer
    import fpseq_pkg::*;
#(
    parameter logic [15:0] ENROLL_TIMEOUT_TICKS = ENROLL_TIMEOUT_DEF,
    parameter logic [15:0] VERIFY_TIMEOUT_TICKS = VERIFY_TIMEOUT_DEF,
    parameter logic [15:0] REPLY_TIMEOUT_TICKS  = REPLY_TIMEOUT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    logic                         push;
    item_t                        push_item;
    logic                         q_valid;
    logic                         q_full;
    item_t                        head;
    logic [$clog2(Q_DEPTH+1)-1:0] q_level;
    back_status_t                 status;

    // Classify incoming transactions
    fpseq_front u_front
    (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (push),
        .item     (push_item)
    );

    // Decouple front and back
    fpseq_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .status    (status),
        .q_valid   (q_valid),
        .q_full    (q_full),
        .head      (head),
        .level     (q_level)
    );

    // Carry out operations and drive results
    fpseq_back #(
        .ENROLL_TIMEOUT_TICKS (ENROLL_TIMEOUT_TICKS),
        .VERIFY_TIMEOUT_TICKS (VERIFY_TIMEOUT_TICKS),
        .REPLY_TIMEOUT_TICKS  (REPLY_TIMEOUT_TICKS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head      (head),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .status    (status)
    );

    // A held second result always sits behind a full result register
    `FPSEQ_ASSERT_NOW(a_pend_behind_out, status.pend_valid, status.out_valid, "pending result with empty output")
    // No transaction leaves the queue while a second result waits
    `FPSEQ_ASSERT_NOW(a_no_pop_on_pend, status.pop, !status.pend_valid && (q_level != '0), "pop while result pending or queue empty")
    // A released second result lands in the output register
    `FPSEQ_ASSERT_NEXT(a_pend_release, status.pend_valid && !out_stall, status.out_valid && !status.pend_valid, "second result lost")

endmodule

// File: rtl/fpseq_front.sv
// ---------------------------------------------------------------------------
// fpseq_front
// Accepts input transactions and classifies them for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpseq_front
    import fpseq_pkg::*;
(
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    input  logic     q_full,
    output logic     push,
    output item_t    item
);

    // Stall while the queue has no free slot
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // Decode the action and precompute reply flags
    always_comb
    begin
        item              = '0;
        item.kind         = EV_TICK;
        item.start_mode   = MODE_IDLE;
        item.request_id   = in_data.request_id;
        item.request_auto = in_data.request_auto;
        item.confirm      = in_data.reply_confirm;
        item.step         = in_data.reply_step;
        item.seq          = in_data.reply_seq;
        item.page         = in_data.reply_page;
        item.score        = in_data.reply_score;
        item.conf_ok      = (in_data.reply_confirm == CONF_OK);
        item.conf_silent  = (in_data.reply_confirm == CONF_SILENT);
        item.ident_hit    = (in_data.reply_page != 16'd0) || (in_data.reply_score != 16'd0);
        unique case (in_data.action)
            ACT_TICK:   item.kind = EV_TICK;
            ACT_REPLY:  item.kind = EV_REPLY;
            ACT_ENROLL:
            begin
                item.kind       = EV_START;
                item.start_mode = MODE_ENROLL;
            end
            ACT_VERIFY:
            begin
                item.kind       = EV_START;
                item.start_mode = MODE_VERIFY;
            end
            ACT_DELETE:
            begin
                item.kind       = EV_START;
                item.start_mode = MODE_DELETE;
            end
            ACT_CLEAR:
            begin
                item.kind       = EV_START;
                item.start_mode = MODE_CLEAR;
            end
            ACT_CANCEL: item.kind = EV_CANCEL;
            ACT_LED:
            begin
                item.kind       = EV_START;
                item.start_mode = MODE_LED;
            end
            default:    item.kind = EV_TICK;
        endcase
    end

endmodule

// File: rtl/fpseq_queue.sv
// ---------------------------------------------------------------------------
// fpseq_queue
// Short FIFO of classified transactions between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpseq_queue
    import fpseq_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  item_t                        push_item,
    input  back_status_t                 status,
    output logic                         q_valid,
    output logic                         q_full,
    output item_t                        head,
    output logic [$clog2(Q_DEPTH+1)-1:0] level
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int LVL_W = $clog2(Q_DEPTH + 1);

    item_t              slot_reg [Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]   level_reg, level_next;

    assign q_valid = (level_reg != '0);
    assign q_full  = (level_reg == LVL_W'(Q_DEPTH));
    assign head    = slot_reg[rd_ptr_reg];
    assign level   = level_reg;

    // Advance pointers and level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (status.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, status.pop})
            2'b10:   level_next = level_reg + 1'b1;
            2'b01:   level_next = level_reg - 1'b1;
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Store incoming transaction
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/fpseq_back.sv
// ---------------------------------------------------------------------------
// fpseq_back
// Runs the operation sequencer and drives the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpseq_back
    import fpseq_pkg::*;
#(
    parameter logic [15:0] ENROLL_TIMEOUT_TICKS = ENROLL_TIMEOUT_DEF,
    parameter logic [15:0] VERIFY_TIMEOUT_TICKS = VERIFY_TIMEOUT_DEF,
    parameter logic [15:0] REPLY_TIMEOUT_TICKS  = REPLY_TIMEOUT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  item_t                head,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    output back_status_t         status
);

    cfg_t       cfg_reg, cfg_next;
    op_mode_t   mode_reg, mode_next;
    phase_t     phase_reg, phase_next;
    logic       await_reg, await_next;
    logic [15:0] wait_reg, wait_next;
    logic [15:0] page_reg, page_next;
    logic       led_auto_reg, led_auto_next;
    logic [2:0] flash_reg, flash_next;

    out_item_t  out_reg, out_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  pend_reg, pend_next;
    logic       pend_valid_reg, pend_valid_next;

    out_item_t  r0, r1;
    logic [1:0] n_res;
    logic [15:0] limit;
    logic       out_free;
    logic       pop;
    logic       busy;

    // Command for an operation in a given phase
    function automatic out_item_t build_cmd(input op_mode_t m, input phase_t ph,
                                            input logic [15:0] tp, input logic la,
                                            input logic [2:0] fc, input cfg_t c);
        out_item_t r;
        r = '0;
        unique case (m)
            MODE_ENROLL: r = mk_cmd(OPC_ENROLL, {tp, c.repeat_count, c.option_word}, 3'd5);
            MODE_VERIFY:
            begin
                unique case (ph)
                    PH_FLASH: r = mk_cmd(OPC_LED_CTRL, {8'h00, 8'h01, 5'd0, fc, 16'h0001}, 3'd4);
                    PH_POLL:  r = mk_cmd(OPC_GET_IMAGE, 40'd0, 3'd0);
                    default:  r = mk_cmd(OPC_IDENTIFY,
                                         {c.score_level, c.range_id, 16'h0400}, 3'd5);
                endcase
            end
            MODE_DELETE: r = mk_cmd(OPC_DELETE, {8'h00, tp, 16'h0001}, 3'd4);
            MODE_CLEAR:  r = mk_cmd(OPC_EMPTY, 40'd0, 3'd0);
            MODE_CANCEL: r = mk_cmd(OPC_CANCEL, 40'd0, 3'd0);
            MODE_LED:    r = mk_cmd(OPC_LED_MODE, {32'd0, la ? LED_AUTO_BYTE : 8'h00}, 3'd1);
            default:     r = '0;
        endcase
        return r;
    endfunction

    // Pop only when both results of the head transaction have room
    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = q_valid && !pend_valid_reg && out_free;
    assign busy     = (mode_reg != MODE_IDLE);

    assign out_valid         = out_valid_reg;
    assign out_data          = out_reg;
    assign status.pop        = pop;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_valid  = out_valid_reg;

    // Timeout limit for the current wait
    always_comb
    begin
        if (mode_reg == MODE_ENROLL)
        begin
            limit = ENROLL_TIMEOUT_TICKS;
        end
        else if (mode_reg == MODE_VERIFY && phase_reg != PH_FLASH && phase_reg != PH_POLL)
        begin
            limit = VERIFY_TIMEOUT_TICKS;
        end
        else
        begin
            limit = REPLY_TIMEOUT_TICKS;
        end
    end

    // Sequencer: next state and results for the head transaction
    always_comb
    begin
        mode_next     = mode_reg;
        phase_next    = phase_reg;
        await_next    = await_reg;
        wait_next     = wait_reg;
        page_next     = page_reg;
        led_auto_next = led_auto_reg;
        flash_next    = flash_reg;
        r0            = '0;
        r1            = '0;
        n_res         = 2'd0;
        unique case (head.kind)
            EV_TICK:
            begin
                if (busy)
                begin
                    if (!await_reg)
                    begin
                        r0         = build_cmd(mode_reg, phase_reg, page_reg, led_auto_reg,
                                               flash_reg, cfg_reg);
                        n_res      = 2'd1;
                        await_next = 1'b1;
                        wait_next  = '0;
                        if (mode_reg == MODE_VERIFY && phase_reg != PH_FLASH &&
                            phase_reg != PH_POLL)
                        begin
                            phase_next = PH_IDENTIFY;
                        end
                    end
                    else if (wait_reg < limit)
                    begin
                        wait_next = wait_reg + 16'd1;
                    end
                    else if (mode_reg == MODE_VERIFY && phase_reg == PH_FLASH)
                    begin
                        // Flash timeout is silent: move on to polling
                        flash_next = LED_OFF;
                        phase_next = PH_POLL;
                        r0         = mk_cmd(OPC_GET_IMAGE, 40'd0, 3'd0);
                        n_res      = 2'd1;
                        await_next = 1'b1;
                        wait_next  = '0;
                    end
                    else if (mode_reg == MODE_VERIFY)
                    begin
                        r0         = mk_note(NOTE_TIMEOUT, 16'd0, 16'd0);
                        n_res      = 2'd1;
                        phase_next = PH_IDENTIFY;
                        flash_next = LED_OFF;
                        await_next = 1'b0;
                        wait_next  = '0;
                    end
                    else
                    begin
                        r0         = mk_note(NOTE_TIMEOUT, 16'd0, 16'd0);
                        n_res      = 2'd1;
                        mode_next  = MODE_IDLE;
                        await_next = 1'b0;
                        wait_next  = '0;
                    end
                end
            end
            EV_REPLY:
            begin
                if (busy && await_reg)
                begin
                    unique case (mode_reg)
                        MODE_ENROLL:
                        begin
                            if (!head.conf_ok)
                            begin
                                r0         = mk_note(NOTE_ENROLL_FAIL, {8'd0, head.confirm},
                                                     {8'd0, head.step});
                                n_res      = 2'd1;
                                mode_next  = MODE_IDLE;
                                await_next = 1'b0;
                                wait_next  = '0;
                            end
                            else if (head.step == STEP_STORED)
                            begin
                                r0         = mk_note(NOTE_ENROLL_OK, page_reg, 16'd0);
                                n_res      = 2'd1;
                                mode_next  = MODE_IDLE;
                                await_next = 1'b0;
                                wait_next  = '0;
                            end
                            else
                            begin
                                wait_next = '0;
                                if (head.step <= STEP_ENROLL_MAX)
                                begin
                                    r0    = mk_note(NOTE_ENROLL_STEP, {8'd0, head.step},
                                                    {8'd0, head.seq});
                                    n_res = 2'd1;
                                end
                            end
                        end
                        MODE_VERIFY:
                        begin
                            if (phase_reg == PH_FLASH)
                            begin
                                flash_next = LED_OFF;
                                phase_next = PH_POLL;
                                r0         = mk_cmd(OPC_GET_IMAGE, 40'd0, 3'd0);
                                n_res      = 2'd1;
                                await_next = 1'b1;
                                wait_next  = '0;
                            end
                            else if (phase_reg == PH_POLL)
                            begin
                                if (!head.conf_ok)
                                begin
                                    // Finger gone: restart at identify
                                    phase_next = PH_IDENTIFY;
                                    flash_next = LED_OFF;
                                    await_next = 1'b0;
                                    wait_next  = '0;
                                end
                                else
                                begin
                                    r0         = mk_cmd(OPC_GET_IMAGE, 40'd0, 3'd0);
                                    n_res      = 2'd1;
                                    await_next = 1'b1;
                                    wait_next  = '0;
                                end
                            end
                            else if (head.conf_ok && head.step != STEP_IDENT)
                            begin
                                wait_next = '0;
                            end
                            else if (head.conf_silent)
                            begin
                                // Silent code: no note, no flash
                                flash_next = LED_OFF;
                                phase_next = PH_POLL;
                                r0         = mk_cmd(OPC_GET_IMAGE, 40'd0, 3'd0);
                                n_res      = 2'd1;
                                await_next = 1'b1;
                                wait_next  = '0;
                            end
                            else
                            begin
                                if (head.conf_ok && head.ident_hit)
                                begin
                                    r0         = mk_note(NOTE_VERIFY_OK, head.page, head.score);
                                    flash_next = LED_GREEN;
                                end
                                else if (head.conf_ok)
                                begin
                                    r0         = mk_note(NOTE_VERIFY_FAIL, CODE_NO_MATCH, 16'd0);
                                    flash_next = LED_RED;
                                end
                                else
                                begin
                                    r0         = mk_note(NOTE_VERIFY_FAIL, {8'd0, head.confirm},
                                                         16'd0);
                                    flash_next = LED_RED;
                                end
                                phase_next = PH_FLASH;
                                r1         = mk_cmd(OPC_LED_CTRL, {8'h00, 8'h01, 5'd0, flash_next,
                                                                   16'h0001}, 3'd4);
                                n_res      = 2'd2;
                                await_next = 1'b1;
                                wait_next  = '0;
                            end
                        end
                        MODE_DELETE:
                        begin
                            r0         = head.conf_ok ? mk_note(NOTE_DELETE_OK, 16'd0, 16'd0)
                                       : mk_note(NOTE_DELETE_FAIL, {8'd0, head.confirm}, 16'd0);
                            n_res      = 2'd1;
                            mode_next  = MODE_IDLE;
                            await_next = 1'b0;
                            wait_next  = '0;
                        end
                        MODE_CLEAR:
                        begin
                            r0         = head.conf_ok ? mk_note(NOTE_CLEAR_OK, 16'd0, 16'd0)
                                       : mk_note(NOTE_CLEAR_FAIL, {8'd0, head.confirm}, 16'd0);
                            n_res      = 2'd1;
                            mode_next  = MODE_IDLE;
                            await_next = 1'b0;
                            wait_next  = '0;
                        end
                        MODE_CANCEL:
                        begin
                            r0         = mk_note(NOTE_CANCELLED, 16'd0, 16'd0);
                            n_res      = 2'd1;
                            mode_next  = MODE_IDLE;
                            await_next = 1'b0;
                            wait_next  = '0;
                        end
                        default:
                        begin
                            r0         = head.conf_ok
                                       ? mk_note(NOTE_LED_OK,
                                                 {8'd0, led_auto_reg ? LED_AUTO_BYTE : 8'h00},
                                                 16'd0)
                                       : mk_note(NOTE_LED_FAIL, {8'd0, head.confirm}, 16'd0);
                            n_res      = 2'd1;
                            mode_next  = MODE_IDLE;
                            await_next = 1'b0;
                            wait_next  = '0;
                        end
                    endcase
                end
            end
            EV_START:
            begin
                if (busy)
                begin
                    r0    = mk_note(NOTE_BUSY, 16'd0, 16'd0);
                    n_res = 2'd1;
                end
                else
                begin
                    if (head.start_mode == MODE_ENROLL || head.start_mode == MODE_DELETE)
                    begin
                        page_next = head.request_id;
                    end
                    if (head.start_mode == MODE_LED)
                    begin
                        led_auto_next = head.request_auto;
                    end
                    if (head.start_mode == MODE_VERIFY)
                    begin
                        phase_next = PH_IDENTIFY;
                        flash_next = LED_OFF;
                    end
                    mode_next  = head.start_mode;
                    await_next = 1'b0;
                    wait_next  = '0;
                end
            end
            EV_CANCEL:
            begin
                mode_next  = MODE_CANCEL;
                await_next = 1'b0;
                wait_next  = '0;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
        // Mark the last result of this transaction
        if (n_res == 2'd1)
        begin
            r0.is_last = 1'b1;
        end
        if (n_res == 2'd2)
        begin
            r1.is_last = 1'b1;
        end
    end

    // Output register and the second-result holding stage
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_next        = pend_reg;
                out_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (pop && n_res != 2'd0)
            begin
                out_next       = r0;
                out_valid_next = 1'b1;
                if (n_res == 2'd2)
                begin
                    pend_next       = r1;
                    pend_valid_next = 1'b1;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    // Configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REPEAT: cfg_next.repeat_count = cfg_data[7:0];
                CFG_OPTION: cfg_next.option_word  = cfg_data;
                CFG_LEVEL:  cfg_next.score_level  = cfg_data[7:0];
                CFG_RANGE:  cfg_next.range_id     = cfg_data;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.repeat_count <= CFG_REPEAT_RST;
            cfg_reg.option_word  <= CFG_OPTION_RST;
            cfg_reg.score_level  <= CFG_LEVEL_RST;
            cfg_reg.range_id     <= CFG_RANGE_RST;
            mode_reg             <= MODE_VERIFY;
            phase_reg            <= PH_IDENTIFY;
            await_reg            <= 1'b0;
            wait_reg             <= '0;
            page_reg             <= '0;
            led_auto_reg         <= 1'b1;
            flash_reg            <= LED_OFF;
            out_valid_reg        <= 1'b0;
            pend_valid_reg       <= 1'b0;
        end
        else
        begin
            cfg_reg        <= cfg_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (pop)
            begin
                mode_reg     <= mode_next;
                phase_reg    <= phase_next;
                await_reg    <= await_next;
                wait_reg     <= wait_next;
                page_reg     <= page_next;
                led_auto_reg <= led_auto_next;
                flash_reg    <= flash_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

endmodule

// File: sim/tb_fingerprint_module_command_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for fingerprint_module_command_sequencer
// Drives module events (ticks, replies, host requests) through the valid/stall
// input channel and checks every command and notification on the output
// channel. A scoreboard carries its own model of the sequencer state and
// configuration. The run starts with a directed pass over verify, enroll,
// delete, clear, LED mode, cancel, busy refusal and the identify, flash, enroll,
// clear and cancel timeouts. It then runs a state-aware random pass under several
// register settings, with random idling on both channels.
// ----------------------------------------------------------------------------

import fpseq_pkg::*;

class fpseq_scoreboard;

    // Register copy
    logic [7:0]  capture_count;
    logic [15:0] option_word;
    logic [7:0]  score_level;
    logic [15:0] range_id;

    // Sequencer state copy
    op_mode_t    mode;
    phase_t      phase;
    bit          awaiting;
    logic [15:0] wait_cnt;
    logic [15:0] target_page;
    bit          led_auto;
    logic [2:0]  flash_color;

    // Results still owed by the block, oldest first
    out_item_t   owed_results[$];
    out_item_t   step_results[$];

    int          n_errors;
    int          n_checked;
    int          n_cmds;
    int          n_notes;

    function new();
        capture_count = CFG_REPEAT_RST;
        option_word   = CFG_OPTION_RST;
        score_level   = CFG_LEVEL_RST;
        range_id      = CFG_RANGE_RST;
        mode          = MODE_VERIFY;
        phase         = PH_IDENTIFY;
        awaiting      = 1'b0;
        wait_cnt      = '0;
        target_page   = '0;
        led_auto      = 1'b1;
        flash_color   = LED_OFF;
        n_errors      = 0;
        n_checked     = 0;
        n_cmds        = 0;
        n_notes       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        case (idx)
            CFG_REPEAT: capture_count = val[7:0];
            CFG_OPTION: option_word   = val;
            CFG_LEVEL:  score_level   = val[7:0];
            default:    range_id      = val;
        endcase
    endfunction

    function void add_cmd(logic [7:0] opc, logic [39:0] bytes, logic [2:0] cnt);
        out_item_t r;
        r                = '0;
        r.result_kind    = KIND_CMD;
        r.cmd_opcode     = opc;
        r.cmd_bytes      = bytes;
        r.cmd_byte_count = cnt;
        step_results.push_back(r);
    endfunction

    function void add_note(logic [3:0] code, logic [15:0] a, logic [15:0] b);
        out_item_t r;
        r             = '0;
        r.result_kind = KIND_NOTE;
        r.note_code   = code;
        r.note_arg_a  = a;
        r.note_arg_b  = b;
        step_results.push_back(r);
    endfunction

    // Issue the command for the current operation and phase, then wait for a reply
    function void issue_command();
        bit sent;
        sent = 1'b1;
        case (mode)
            MODE_ENROLL:
                add_cmd(OPC_ENROLL, {target_page, capture_count, option_word}, 3'd5);
            MODE_VERIFY:
                if (phase == PH_FLASH)
                    add_cmd(OPC_LED_CTRL, {8'h00, 8'h01, 5'b0, flash_color, 8'h00, 8'h01},
                            3'd4);
                else if (phase == PH_POLL)
                    add_cmd(OPC_GET_IMAGE, 40'h0, 3'd0);
                else
                begin
                    phase = PH_IDENTIFY;
                    add_cmd(OPC_IDENTIFY, {score_level, range_id, 16'h0400}, 3'd5);
                end
            MODE_DELETE:
                add_cmd(OPC_DELETE, {8'h00, target_page, 16'h0001}, 3'd4);
            MODE_CLEAR:
                add_cmd(OPC_EMPTY, 40'h0, 3'd0);
            MODE_CANCEL:
                add_cmd(OPC_CANCEL, 40'h0, 3'd0);
            MODE_LED:
                add_cmd(OPC_LED_MODE, {32'h0, led_auto ? LED_AUTO_BYTE : 8'h00}, 3'd1);
            default:
                sent = 1'b0;
        endcase
        if (sent)
        begin
            awaiting = 1'b1;
            wait_cnt = '0;
        end
    endfunction

    function void end_operation();
        mode     = MODE_IDLE;
        awaiting = 1'b0;
        wait_cnt = '0;
    endfunction

    function void restart_verify();
        phase       = PH_IDENTIFY;
        flash_color = LED_OFF;
        awaiting    = 1'b0;
        wait_cnt    = '0;
    endfunction

    function logic [15:0] wait_limit();
        if (mode == MODE_ENROLL)
            return ENROLL_TIMEOUT_DEF;
        if (mode == MODE_VERIFY && phase == PH_IDENTIFY)
            return VERIFY_TIMEOUT_DEF;
        return REPLY_TIMEOUT_DEF;
    endfunction

    function void on_tick();
        if (mode == MODE_IDLE)
            return;
        if (!awaiting)
        begin
            issue_command();
            return;
        end
        if (wait_cnt < wait_limit())
        begin
            wait_cnt++;
            return;
        end
        // A lost LED flash ack is silent: move on to polling
        if (mode == MODE_VERIFY && phase == PH_FLASH)
        begin
            flash_color = LED_OFF;
            phase       = PH_POLL;
            issue_command();
            return;
        end
        add_note(NOTE_TIMEOUT, 16'h0, 16'h0);
        if (mode == MODE_VERIFY)
            restart_verify();
        else
            end_operation();
    endfunction

    function void on_verify_reply(in_item_t it);
        if (phase == PH_FLASH)
        begin
            flash_color = LED_OFF;
            phase       = PH_POLL;
            issue_command();
        end
        else if (phase == PH_POLL)
        begin
            // Finger gone ends the poll, otherwise poll again
            if (it.reply_confirm != CONF_OK)
                restart_verify();
            else
                issue_command();
        end
        else if (it.reply_confirm == CONF_OK && it.reply_step != STEP_IDENT)
            wait_cnt = '0;
        else if (it.reply_confirm == CONF_SILENT)
        begin
            flash_color = LED_OFF;
            phase       = PH_POLL;
            issue_command();
        end
        else
        begin
            if (it.reply_confirm == CONF_OK)
            begin
                if (it.reply_page != 16'h0 || it.reply_score != 16'h0)
                begin
                    add_note(NOTE_VERIFY_OK, it.reply_page, it.reply_score);
                    flash_color = LED_GREEN;
                end
                else
                begin
                    add_note(NOTE_VERIFY_FAIL, CODE_NO_MATCH, 16'h0);
                    flash_color = LED_RED;
                end
            end
            else
            begin
                add_note(NOTE_VERIFY_FAIL, {8'h00, it.reply_confirm}, 16'h0);
                flash_color = LED_RED;
            end
            phase = PH_FLASH;
            issue_command();
        end
    endfunction

    function void on_reply(in_item_t it);
        logic ok;
        ok = (it.reply_confirm == CONF_OK);
        // Drop stray replies
        if (!awaiting || mode == MODE_IDLE)
            return;
        case (mode)
            MODE_ENROLL:
                if (!ok)
                begin
                    add_note(NOTE_ENROLL_FAIL, {8'h00, it.reply_confirm},
                             {8'h00, it.reply_step});
                    end_operation();
                end
                else if (it.reply_step == STEP_STORED)
                begin
                    add_note(NOTE_ENROLL_OK, target_page, 16'h0);
                    end_operation();
                end
                else
                begin
                    wait_cnt = '0;
                    if (it.reply_step <= STEP_ENROLL_MAX)
                        add_note(NOTE_ENROLL_STEP, {8'h00, it.reply_step},
                                 {8'h00, it.reply_seq});
                end
            MODE_VERIFY:
                on_verify_reply(it);
            MODE_DELETE:
            begin
                if (ok)
                    add_note(NOTE_DELETE_OK, 16'h0, 16'h0);
                else
                    add_note(NOTE_DELETE_FAIL, {8'h00, it.reply_confirm}, 16'h0);
                end_operation();
            end
            MODE_CLEAR:
            begin
                if (ok)
                    add_note(NOTE_CLEAR_OK, 16'h0, 16'h0);
                else
                    add_note(NOTE_CLEAR_FAIL, {8'h00, it.reply_confirm}, 16'h0);
                end_operation();
            end
            MODE_CANCEL:
            begin
                add_note(NOTE_CANCELLED, 16'h0, 16'h0);
                end_operation();
            end
            default:
            begin
                if (ok)
                    add_note(NOTE_LED_OK, {8'h00, led_auto ? LED_AUTO_BYTE : 8'h00}, 16'h0);
                else
                    add_note(NOTE_LED_FAIL, {8'h00, it.reply_confirm}, 16'h0);
                end_operation();
            end
        endcase
    endfunction

    function void on_request(op_mode_t m, in_item_t it);
        if (mode != MODE_IDLE)
        begin
            add_note(NOTE_BUSY, 16'h0, 16'h0);
            return;
        end
        if (m == MODE_ENROLL || m == MODE_DELETE)
            target_page = it.request_id;
        if (m == MODE_LED)
            led_auto = it.request_auto;
        if (m == MODE_VERIFY)
        begin
            phase       = PH_IDENTIFY;
            flash_color = LED_OFF;
        end
        mode     = m;
        awaiting = 1'b0;
        wait_cnt = '0;
    endfunction

    // Advance the model by one accepted transaction and queue what it owes
    function void accept_event(in_item_t it);
        out_item_t r;
        step_results.delete();
        case (it.action)
            ACT_TICK:   on_tick();
            ACT_REPLY:  on_reply(it);
            ACT_ENROLL: on_request(MODE_ENROLL, it);
            ACT_VERIFY: on_request(MODE_VERIFY, it);
            ACT_DELETE: on_request(MODE_DELETE, it);
            ACT_CLEAR:  on_request(MODE_CLEAR, it);
            ACT_CANCEL:
            begin
                mode     = MODE_CANCEL;
                awaiting = 1'b0;
                wait_cnt = '0;
            end
            default:    on_request(MODE_LED, it);
        endcase
        if (step_results.size() > 0)
        begin
            r         = step_results.pop_back();
            r.is_last = 1'b1;
            step_results.push_back(r);
        end
        foreach (step_results[i])
            owed_results.push_back(step_results[i]);
    endfunction

    function void compare_field(string name, logic [39:0] exp_v, logic [39:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, got_v);
            n_errors++;
        end
    endfunction

    function void check_result(out_item_t got);
        out_item_t exp;
        if (owed_results.size() == 0)
        begin
            $error("result with nothing owed: kind %0d opcode 0x%0h note %0d",
                   got.result_kind, got.cmd_opcode, got.note_code);
            n_errors++;
            return;
        end
        exp = owed_results.pop_front();
        n_checked++;
        if (exp.result_kind == KIND_CMD)
            n_cmds++;
        else
            n_notes++;
        compare_field("result_kind", 40'(exp.result_kind), 40'(got.result_kind));
        compare_field("cmd_opcode", 40'(exp.cmd_opcode), 40'(got.cmd_opcode));
        compare_field("cmd_bytes", exp.cmd_bytes, got.cmd_bytes);
        compare_field("cmd_byte_count", 40'(exp.cmd_byte_count), 40'(got.cmd_byte_count));
        compare_field("note_code", 40'(exp.note_code), 40'(got.note_code));
        compare_field("note_arg_a", 40'(exp.note_arg_a), 40'(got.note_arg_a));
        compare_field("note_arg_b", 40'(exp.note_arg_b), 40'(got.note_arg_b));
        compare_field("is_last", 40'(exp.is_last), 40'(got.is_last));
    endfunction

endclass

module tb_fingerprint_module_command_sequencer;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int IDLE_PCT     = 26;
    localparam int DRAIN_CYCLES = 8;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    bit                   calm = 1'b0;
    int                   cycle_count;
    int                   n_sent;
    fpseq_scoreboard      sb = new();

    fingerprint_module_command_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up on a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Check each accepted result, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    function automatic in_item_t scatter();
        in_item_t e;
        e.action        = 3'($urandom_range(0, 7));
        e.request_id    = 16'($urandom);
        e.request_auto  = 1'($urandom);
        e.reply_confirm = 8'($urandom);
        e.reply_step    = 8'($urandom);
        e.reply_seq     = 8'($urandom);
        e.reply_page    = 16'($urandom);
        e.reply_score   = 16'($urandom);
        return e;
    endfunction

    function automatic in_item_t ev(logic [2:0] act);
        in_item_t e;
        e        = '0;
        e.action = act;
        return e;
    endfunction

    function automatic in_item_t ev_request(logic [2:0] act, logic [15:0] id, logic led_mode);
        in_item_t e;
        e              = ev(act);
        e.request_id   = id;
        e.request_auto = led_mode;
        return e;
    endfunction

    function automatic in_item_t ev_reply(logic [7:0] conf, logic [7:0] step, logic [7:0] seq,
                                          logic [15:0] page, logic [15:0] score);
        in_item_t e;
        e               = ev(ACT_REPLY);
        e.reply_confirm = conf;
        e.reply_step    = step;
        e.reply_seq     = seq;
        e.reply_page    = page;
        e.reply_score   = score;
        return e;
    endfunction

    function automatic logic [2:0] pick_request();
        case ($urandom_range(0, 4))
            0:       return ACT_ENROLL;
            1:       return ACT_VERIFY;
            2:       return ACT_DELETE;
            3:       return ACT_CLEAR;
            default: return ACT_LED;
        endcase
    endfunction

    // Choose a transaction that fits the current state, with some noise mixed in
    function automatic in_item_t next_event();
        in_item_t e;
        int       r;
        e = scatter();
        r = $urandom_range(0, 99);
        if (r < 12)
            return e;
        if (sb.mode == MODE_IDLE)
        begin
            e.action = ($urandom_range(0, 5) == 0) ? ACT_CANCEL : pick_request();
            if ($urandom_range(0, 3) == 0)
                e.request_id = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
            return e;
        end
        if (r < 17)
        begin
            e.action = pick_request();
            return e;
        end
        if (r < 20)
        begin
            e.action = ACT_CANCEL;
            return e;
        end
        if (!sb.awaiting || r < 28)
        begin
            e.action = ACT_TICK;
            return e;
        end
        e.action = ACT_REPLY;
        r = $urandom_range(0, 99);
        case (sb.mode)
            MODE_ENROLL:
            begin
                e.reply_confirm = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255))
                                                              : CONF_OK;
                if (r < 70)
                    e.reply_step = 8'($urandom_range(0, 5));
                else if (r < 85)
                    e.reply_step = STEP_STORED;
                else
                    e.reply_step = 8'($urandom_range(7, 255));
            end
            MODE_VERIFY:
                if (sb.phase == PH_IDENTIFY)
                begin
                    if (r < 55)
                    begin
                        e.reply_confirm = CONF_OK;
                        e.reply_step    = STEP_IDENT;
                        if (r < 8)
                        begin
                            e.reply_page  = 16'h0;
                            e.reply_score = 16'h0;
                        end
                        else if (r < 14)
                            e.reply_page = 16'h0;
                    end
                    else if (r < 70)
                        e.reply_confirm = CONF_SILENT;
                    else if (r < 85)
                        e.reply_confirm = 8'($urandom_range(1, 255));
                    else
                        e.reply_confirm = CONF_OK;
                end
                else if (sb.phase == PH_POLL && r < 70)
                    e.reply_confirm = CONF_OK;
            default:
                if (r < 60)
                    e.reply_confirm = CONF_OK;
        endcase
        return e;
    endfunction

    // Offer one transaction and hold it until accepted
    task automatic send(input in_item_t e);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.accept_event(e);
        n_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n)
            send(ev(ACT_TICK));
    endtask

    // Drop valid and wait until everything owed has arrived
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_cfg(input logic [7:0] cap, input logic [15:0] opt,
                               input logic [7:0] lvl, input logic [15:0] rng);
        write_cfg(CFG_REPEAT, {8'h00, cap});
        write_cfg(CFG_OPTION, opt);
        write_cfg(CFG_LEVEL, {8'h00, lvl});
        write_cfg(CFG_RANGE, rng);
    endtask

    task automatic run_random(input int n);
        repeat (n)
        begin
            // Now and then let a short reply wait run out
            if (sb.awaiting && sb.wait_limit() == REPLY_TIMEOUT_DEF &&
                $urandom_range(0, 99) < 3)
                send_ticks(int'(REPLY_TIMEOUT_DEF) + 1);
            send(next_event());
        end
    endtask

    task automatic run_directed();
        // Verify loop from reset: match, flash ack, finger still there, finger gone
        send(ev(ACT_TICK));
        send(ev_reply(CONF_OK, STEP_IDENT, 8'h00, 16'h1234, 16'hFFFF));
        send(ev_reply(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
        send(ev_reply(CONF_OK, 8'h00, 8'h00, 16'h0, 16'h0));
        send(ev_reply(8'h01, 8'h00, 8'h00, 16'h0, 16'h0));
        // Unknown identify step, then no match with red flash and a lost flash ack
        send(ev(ACT_TICK));
        send(ev_reply(CONF_OK, 8'h03, 8'h00, 16'h0, 16'h0));
        send(ev_reply(CONF_OK, STEP_IDENT, 8'h00, 16'h0, 16'h0));
        send_ticks(int'(REPLY_TIMEOUT_DEF) + 1);
        send(ev_reply(8'h80, 8'h00, 8'h00, 16'h0, 16'h0));
        // Silent code goes straight to polling
        send(ev(ACT_TICK));
        send(ev_reply(CONF_SILENT, 8'h00, 8'h00, 16'h0, 16'h0));
        send(ev_reply(8'h02, 8'h00, 8'h00, 16'h0, 16'h0));
        // Error code from identify, busy refusal mid-poll
        send(ev(ACT_TICK));
        send(ev_reply(8'hFF, STEP_IDENT, 8'h00, 16'h0, 16'h0));
        send(ev_reply(CONF_OK, 8'h00, 8'h00, 16'h0, 16'h0));
        send(ev_request(ACT_ENROLL, 16'h0001, 1'b0));
        send(ev_reply(8'h01, 8'h00, 8'h00, 16'h0, 16'h0));
        // Identify timeout restarts verify
        send(ev(ACT_TICK));
        send_ticks(int'(VERIFY_TIMEOUT_DEF) + 1);
        // Cancel to idle, then stray reply and idle tick
        send(ev(ACT_CANCEL));
        send(ev(ACT_TICK));
        send(ev_reply(8'hFF, 8'h00, 8'h00, 16'h0, 16'h0));
        send(ev_reply(CONF_OK, 8'h00, 8'h00, 16'h0, 16'h0));
        send(ev(ACT_TICK));
        // Enroll with steps, ignored step, busy refusal and store
        send(ev_request(ACT_ENROLL, 16'hFFFF, 1'b1));
        send(ev(ACT_TICK));
        send(ev_reply(CONF_OK, 8'h00, 8'h00, 16'h0, 16'h0));
        send(ev_reply(CONF_OK, STEP_ENROLL_MAX, 8'hFF, 16'h0, 16'h0));
        send(ev_reply(CONF_OK, 8'hFF, 8'h01, 16'h0, 16'h0));
        send(ev_request(ACT_VERIFY, 16'h0, 1'b0));
        send(ev_reply(CONF_OK, STEP_STORED, 8'h00, 16'h0, 16'h0));
        // Enroll failure and enroll timeout
        send(ev_request(ACT_ENROLL, 16'h0000, 1'b0));
        send(ev(ACT_TICK));
        send(ev_reply(8'h0A, 8'h03, 8'h00, 16'h0, 16'h0));
        send(ev_request(ACT_ENROLL, 16'h0001, 1'b0));
        send(ev(ACT_TICK));
        send_ticks(int'(ENROLL_TIMEOUT_DEF) + 1);
        // Delete ok and fail
        send(ev_request(ACT_DELETE, 16'hABCD, 1'b0));
        send(ev(ACT_TICK));
        send(ev_reply(CONF_OK, 8'h00, 8'h00, 16'h0, 16'h0));
        send(ev_request(ACT_DELETE, 16'h0000, 1'b0));
        send(ev(ACT_TICK));
        send(ev_reply(8'hFF, 8'h00, 8'h00, 16'h0, 16'h0));
        // Clear ok, then clear that times out
        send(ev_request(ACT_CLEAR, 16'h0, 1'b0));
        send(ev(ACT_TICK));
        send(ev_reply(CONF_OK, 8'h00, 8'h00, 16'h0, 16'h0));
        send(ev_request(ACT_CLEAR, 16'h0, 1'b0));
        send(ev(ACT_TICK));
        send_ticks(int'(REPLY_TIMEOUT_DEF) + 1);
        // LED mode manual ok, automatic fail
        send(ev_request(ACT_LED, 16'h0, 1'b0));
        send(ev(ACT_TICK));
        send(ev_reply(CONF_OK, 8'h00, 8'h00, 16'h0, 16'h0));
        send(ev_request(ACT_LED, 16'h0, 1'b1));
        send(ev(ACT_TICK));
        send(ev_reply(8'h33, 8'h00, 8'h00, 16'h0, 16'h0));
        // Cancel during a delete, cancel wait runs out with no cancelled note
        send(ev_request(ACT_DELETE, 16'h0005, 1'b0));
        send(ev(ACT_TICK));
        send(ev(ACT_CANCEL));
        send(ev(ACT_TICK));
        send_ticks(int'(REPLY_TIMEOUT_DEF) + 1);
        // Back into verify; score alone counts as a match
        send(ev_request(ACT_VERIFY, 16'h0, 1'b0));
        send(ev(ACT_TICK));
        send(ev_reply(CONF_OK, STEP_IDENT, 8'h00, 16'h0, 16'h0001));
    endtask

    initial
    begin
        n_sent    = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_REPEAT;
        cfg_data  <= 16'h0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass at reset register values
        run_directed();
        drain();

        // All registers at their maximum
        program_cfg(8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF);
        run_random(250);
        drain();

        // All registers at zero, part of it with no idling on either side
        program_cfg(8'h00, 16'h0000, 8'h00, 16'h0000);
        calm <= 1'b1;
        run_random(150);
        calm <= 1'b0;
        run_random(100);
        drain();

        // Random register values
        program_cfg(8'($urandom_range(0, 255)), 16'($urandom), 8'($urandom_range(0, 255)),
                    16'($urandom));
        run_random(300);
        drain();

        $display("Covered %0d input transactions under four register settings,", n_sent);
        $display("checked %0d results: %0d commands and %0d notifications",
                 sb.n_checked, sb.n_cmds, sb.n_notes);
        if (sb.n_errors == 0 && sb.owed_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: fingerprint_module_command_sequencer.f
+incdir+rtl
rtl/fpseq_pkg.sv
rtl/fpseq_front.sv
rtl/fpseq_queue.sv
rtl/fpseq_back.sv
rtl/fingerprint_module_command_sequencer.sv
sim/tb_fingerprint_module_command_sequencer.sv
